[rtl/cwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_pkg: shared types and constants for congestion window control
// Event codes, reset values and the packed result word.
// ----------------------------------------------------------------------------
package cwc_pkg;

  // Event kinds carried on the input stream.
  typedef enum logic [1:0] {
    OpAck  = 2'd0,
    OpLoss = 2'd1,
    OpRtt  = 2'd2,
    OpNone = 2'd3
  } op_e;

  localparam int unsigned FieldBits = 16;

  // Reset values of the state.
  localparam logic [FieldBits-1:0] InitWindow    = 16'd10;
  localparam logic [FieldBits-1:0] InitThreshold = 16'hFFFF;
  localparam logic [FieldBits-1:0] InitRtt       = 16'd100;
  localparam logic [FieldBits-1:0] InitMinWindow = 16'd2;

  // One result word, as reported after each event.
  typedef struct packed {
    logic                 in_slow_start;
    logic [FieldBits-1:0] smoothed_rtt;
    logic [FieldBits-1:0] slow_start_threshold;
    logic [FieldBits-1:0] window;
  } result_t;

endpackage

[rtl/congestion_window_control_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// congestion_window_control_top: Reno-style congestion window control
// Keeps window, slow start threshold, ack counter and smoothed RTT, updated
// by one event word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one event per word: tuser holds the event kind
//   (ack, loss, RTT sample, or an unused code that changes nothing) and
//   tdata the RTT sample. Each accepted word yields exactly one result word
//   with the window, threshold, smoothed RTT and slow start flag after that
//   event.
//   The minimum window register is written through cfg_we_i / cfg_wdata_i;
//   the user must do so only while no event is in flight, unchecked by the block.
//   Flow: an accepted word waits in the input register, is updated from there
//   combinationally, and its result is registered in the result register
//   once that slot is free or drains.
//   Throughput: one event per cycle while the receiver holds tready high. The
//   state registers close a loop through a single compare-and-add stage, so
//   back-to-back events chain without gaps.
//   Stall: when the receiver holds tready low, the result register keeps
//   its word and state does not move; the input register still takes one
//   more word, then tready to the sender drops until the result drains.
//   Reset: window 10, threshold 65535 (saturated to the window width), ack
//   counter 0, smoothed RTT 100, minimum window 2; both stages empty.
// ----------------------------------------------------------------------------
module congestion_window_control_top #(
  parameter int unsigned WindowBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Minimum window register.
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Event stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] rtt_sample
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [15:0] window, [31:16] slow_start_threshold,
                                      // [47:32] smoothed_rtt, [48] in_slow_start, rest 0
);

  localparam logic [WindowBits-1:0] InitWin = WindowBits'(cwc_pkg::InitWindow);
  localparam logic [WindowBits-1:0] InitThr =
    (WindowBits >= 16) ? WindowBits'(cwc_pkg::InitThreshold) : '1;

  logic                  in_valid_q, in_valid_d;
  cwc_pkg::op_e          op_q;
  logic [15:0]           sample_q;
  logic                  out_valid_q, out_valid_d;
  cwc_pkg::result_t      result_q;
  logic [15:0]           min_window_q;
  logic [WindowBits-1:0] cwnd_q, cwnd_d;
  logic [WindowBits-1:0] thresh_q, thresh_d;
  logic [WindowBits-1:0] ack_q, ack_d;
  logic [15:0]           rtt_q, rtt_d;
  cwc_pkg::result_t      result_d;
  logic                  advance;
  logic                  fire;
  logic                  s_accept;

  // Handshake: the update stage fires when the result slot is free or drains.
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q     <= cwc_pkg::op_e'(s_axis_tuser);
      sample_q <= s_axis_tdata;
    end
  end

  // Next-state logic for the registered event.
  cwc_update #(
    .WindowBits (WindowBits)
  ) u_update (
    .op_i         (op_q),
    .rtt_sample_i (sample_q),
    .min_window_i (min_window_q),
    .cwnd_i       (cwnd_q),
    .thresh_i     (thresh_q),
    .ack_count_i  (ack_q),
    .rtt_avg_i    (rtt_q),
    .cwnd_o       (cwnd_d),
    .thresh_o     (thresh_d),
    .ack_count_o  (ack_d),
    .rtt_avg_o    (rtt_d),
    .result_o     (result_d)
  );

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      min_window_q <= cwc_pkg::InitMinWindow;
      cwnd_q       <= InitWin;
      thresh_q     <= InitThr;
      ack_q        <= '0;
      rtt_q        <= cwc_pkg::InitRtt;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        min_window_q <= cfg_wdata_i;
      end
      if (fire) begin
        cwnd_q   <= cwnd_d;
        thresh_q <= thresh_d;
        ack_q    <= ack_d;
        rtt_q    <= rtt_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, result_q};

`ifndef SYNTHESIS
  // State must not move while a finished word is held by the receiver.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(cwnd_q) && $stable(ack_q) && $stable(rtt_q)))
    else $error("state changed while result stalled");

  // A processed loss event drops the window to the configured floor.
  a_loss_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && op_q == cwc_pkg::OpLoss) |=> (cwnd_q <= WindowBits'($past(min_window_q))))
    else $error("loss did not set window to floor");

  // A processed event always produces a result word in the next cycle.
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("processed event produced no result");
`endif

endmodule

[rtl/cwc_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_update: next-state logic for one event
// Computes the new window, threshold, ack counter and smoothed RTT from the
// current state and one registered event, and forms the result word.
// ----------------------------------------------------------------------------
module cwc_update #(
  parameter int unsigned WindowBits = 16
) (
  input  cwc_pkg::op_e            op_i,
  input  logic [15:0]             rtt_sample_i,
  input  logic [15:0]             min_window_i,
  input  logic [WindowBits-1:0]   cwnd_i,
  input  logic [WindowBits-1:0]   thresh_i,
  input  logic [WindowBits-1:0]   ack_count_i,
  input  logic [15:0]             rtt_avg_i,
  output logic [WindowBits-1:0]   cwnd_o,
  output logic [WindowBits-1:0]   thresh_o,
  output logic [WindowBits-1:0]   ack_count_o,
  output logic [15:0]             rtt_avg_o,
  output cwc_pkg::result_t        result_o
);

  logic [WindowBits-1:0] floor_w;
  logic [WindowBits-1:0] grown;
  logic [WindowBits-1:0] half;
  logic [WindowBits:0]   ack_next;
  logic [18:0]           rtt_x7;
  logic [19:0]           rtt_sum;
  logic [15:0]           cwnd_lo;
  logic [15:0]           thresh_lo;

  // Minimum window saturated to the window width.
  if (WindowBits >= 16) begin : g_floor_wide
    assign floor_w = WindowBits'(min_window_i);
  end else begin : g_floor_narrow
    assign floor_w = (|min_window_i[15:WindowBits]) ? '1 : min_window_i[WindowBits-1:0];
  end

  // Saturating increment, halving and the counter step.
  assign grown    = (&cwnd_i) ? cwnd_i : cwnd_i + 1'b1;
  assign half     = cwnd_i >> 1;
  assign ack_next = {1'b0, ack_count_i} + 1'b1;

  // Smoothed RTT: (7 * old + sample) / 8, low 16 bits kept.
  assign rtt_x7  = {rtt_avg_i, 3'b000} - {3'b000, rtt_avg_i};
  assign rtt_sum = {1'b0, rtt_x7} + {4'b0000, rtt_sample_i};

  // State update per event kind.
  always_comb begin
    cwnd_o      = cwnd_i;
    thresh_o    = thresh_i;
    ack_count_o = ack_count_i;
    rtt_avg_o   = rtt_avg_i;
    unique case (op_i)
      cwc_pkg::OpAck: begin
        if (cwnd_i < thresh_i) begin
          cwnd_o = grown;
        end else if (ack_next >= {1'b0, cwnd_i}) begin
          cwnd_o      = grown;
          ack_count_o = '0;
        end else begin
          ack_count_o = ack_next[WindowBits-1:0];
        end
      end
      cwc_pkg::OpLoss: begin
        thresh_o = (half > floor_w) ? half : floor_w;
        cwnd_o   = floor_w;
      end
      cwc_pkg::OpRtt: begin
        rtt_avg_o = rtt_sum[18:3];
      end
      cwc_pkg::OpNone: begin
        rtt_avg_o = rtt_avg_i;
      end
      default: begin
        rtt_avg_o = rtt_avg_i;
      end
    endcase
  end

  // Window-width values fitted to 16 bits for the result (low bits kept, or zero-extended).
  if (WindowBits >= 16) begin : g_out_wide
    assign cwnd_lo   = cwnd_o[15:0];
    assign thresh_lo = thresh_o[15:0];
  end else begin : g_out_narrow
    assign cwnd_lo   = {{(16-WindowBits){1'b0}}, cwnd_o};
    assign thresh_lo = {{(16-WindowBits){1'b0}}, thresh_o};
  end

  always_comb begin
    result_o.window               = cwnd_lo;
    result_o.slow_start_threshold = thresh_lo;
    result_o.smoothed_rtt         = rtt_avg_o;
    result_o.in_slow_start        = (cwnd_o < thresh_o);
  end

endmodule
